// File: rtl/lmgs_pkg.sv
// Shared types, codes and glyph tables for the LED glyph scroller.
// No dependencies; every other file imports this package.
`default_nettype none

package lmgs_pkg;

  localparam int unsigned ROW_COUNT = 8;
  localparam int unsigned ROW_W     = 3;

  localparam logic [1:0]  MODE_IDLE = 2'd0;
  localparam logic [1:0]  MODE_UP   = 2'd1;
  localparam logic [1:0]  MODE_DOWN = 2'd2;

  localparam logic [15:0] PERIOD_RESET = 16'd100;
  localparam logic [ROW_W-1:0] LAST_ROW_IDX = 3'd7;

  localparam logic [7:0] FLOOR_FIRST = 8'd1;
  localparam logic [7:0] FLOOR_LAST  = 8'd4;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic update;
    logic emit;
  } lmgs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic row_last;
    logic out_free;
  } lmgs_sts_t;

  function automatic logic [7:0] up_arrow_row(input logic [ROW_W-1:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = 8'h00;
      3'd1:    r = 8'h18;
      3'd2:    r = 8'h3C;
      3'd3:    r = 8'h7E;
      3'd4:    r = 8'h18;
      3'd5:    r = 8'h18;
      3'd6:    r = 8'h18;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] down_arrow_row(input logic [ROW_W-1:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = 8'h00;
      3'd1:    r = 8'h18;
      3'd2:    r = 8'h18;
      3'd3:    r = 8'h18;
      3'd4:    r = 8'h7E;
      3'd5:    r = 8'h3C;
      3'd6:    r = 8'h18;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // sel is floor minus one
  function automatic logic [7:0] digit_row(input logic [1:0] sel,
                                           input logic [ROW_W-1:0] idx);
    logic [7:0] r;
    unique case ({sel, idx})
      5'b00_000: r = 8'h08;
      5'b00_001: r = 8'h18;
      5'b00_010: r = 8'h28;
      5'b00_011: r = 8'h08;
      5'b00_100: r = 8'h08;
      5'b00_101: r = 8'h08;
      5'b00_110: r = 8'h08;
      5'b00_111: r = 8'h7E;
      5'b01_000: r = 8'h18;
      5'b01_001: r = 8'h24;
      5'b01_010: r = 8'h24;
      5'b01_011: r = 8'h04;
      5'b01_100: r = 8'h08;
      5'b01_101: r = 8'h10;
      5'b01_110: r = 8'h20;
      5'b01_111: r = 8'h7E;
      5'b10_000: r = 8'h18;
      5'b10_001: r = 8'h24;
      5'b10_010: r = 8'h24;
      5'b10_011: r = 8'h04;
      5'b10_100: r = 8'h08;
      5'b10_101: r = 8'h24;
      5'b10_110: r = 8'h24;
      5'b10_111: r = 8'h18;
      5'b11_000: r = 8'h00;
      5'b11_001: r = 8'h08;
      5'b11_010: r = 8'h18;
      5'b11_011: r = 8'h28;
      5'b11_100: r = 8'h7E;
      5'b11_101: r = 8'h08;
      5'b11_110: r = 8'h08;
      default:   r = 8'h08;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/lmgs_ifs.sv
// Valid/ready channel interfaces for refresh requests and row scan results.
// Depends on lmgs_pkg.
`default_nettype none

interface lmgs_in_if
  import lmgs_pkg::*;
;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  floor;
  logic [31:0] now_ms;

  modport source (output valid, output mode, output floor, output now_ms, input ready);
  modport sink   (input valid, input mode, input floor, input now_ms, output ready);
endinterface

interface lmgs_out_if
  import lmgs_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [7:0] row_select;
  logic [7:0] column_bits;
  logic       last_row;

  modport source (output valid, output row_select, output column_bits, output last_row,
                  input ready);
  modport sink   (input valid, input row_select, input column_bits, input last_row,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/lmgs_ctrl.sv
// Request sequencer: accept, frame update, eight-row scan.
// Depends on lmgs_pkg; drives commands into lmgs_datapath.
`default_nettype none

module lmgs_ctrl
  import lmgs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire lmgs_sts_t sts,
  output lmgs_cmd_t      cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_UPDATE = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_ready    = (state_r == S_IDLE);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.update  = (state_r == S_UPDATE);
  assign cmd.emit    = (state_r == S_SCAN) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.capture) state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        // leave after the eighth row is handed to the output register
        if (cmd.emit && sts.row_last) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  a_capture_to_update: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == S_UPDATE))
    else $error("request accepted but no frame update followed");

  a_update_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> (state_r == S_SCAN) && !in_ready)
    else $error("scan did not follow frame update");

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.row_last) |=> in_ready)
    else $error("not ready after last row");

  a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !cmd.emit && !cmd.update)
    else $error("datapath command while idle");
`endif

endmodule

`default_nettype wire

// File: rtl/lmgs_datapath.sv
// Frame store, scroll timers and phases, row counter and output register.
// Depends on lmgs_pkg; commanded by lmgs_ctrl.
`default_nettype none

module lmgs_datapath
  import lmgs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic [1:0]  in_mode,
  input  wire logic [7:0]  in_floor,
  input  wire logic [31:0] in_now_ms,
  input  wire lmgs_cmd_t   cmd,
  output lmgs_sts_t        sts,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic [7:0]       out_row_select,
  output logic [7:0]       out_column_bits,
  output logic             out_last_row
);

  logic [15:0]      period_r;
  logic [1:0]       mode_r;
  logic [7:0]       floor_r;
  logic [31:0]      now_r;
  logic [31:0]      up_last_r, down_last_r;
  logic [ROW_W-1:0] up_phase_r, down_phase_r;
  logic [7:0]       frame_r   [ROW_COUNT];
  logic [7:0]       frame_nxt [ROW_COUNT];
  logic [ROW_W-1:0] row_r;
  logic             out_valid_r;
  logic [7:0]       row_sel_r, col_r;
  logic             last_r;

  logic [31:0] elapsed;
  logic        advance;
  logic        floor_ok;
  logic [1:0]  digit_sel;

  // elapsed time wraps modulo 2^32
  assign elapsed   = now_r - ((mode_r == MODE_UP) ? up_last_r : down_last_r);
  assign advance   = (elapsed >= {16'd0, period_r});
  assign floor_ok  = (floor_r >= FLOOR_FIRST) && (floor_r <= FLOOR_LAST);
  assign digit_sel = 2'(floor_r - FLOOR_FIRST);

  always_comb begin
    for (int i = 0; i < ROW_COUNT; i++) begin
      frame_nxt[i] = frame_r[i];
      case (mode_r)
        MODE_UP: begin
          if (advance) frame_nxt[i] = up_arrow_row(ROW_W'(i) + up_phase_r);
        end
        MODE_DOWN: begin
          if (advance) frame_nxt[i] = down_arrow_row(ROW_W'(i) - down_phase_r);
        end
        default: begin
          // idle and the unused code show the floor digit, if it has one
          if (floor_ok) frame_nxt[i] = digit_row(digit_sel, ROW_W'(i));
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= in_mode;
      floor_r <= in_floor;
      now_r   <= in_now_ms;
    end
    if (cmd.emit) begin
      row_sel_r <= ~(8'd1 << row_r);
      col_r     <= frame_r[row_r];
      last_r    <= (row_r == LAST_ROW_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r     <= PERIOD_RESET;
      up_last_r    <= '0;
      down_last_r  <= '0;
      up_phase_r   <= '0;
      down_phase_r <= '0;
      row_r        <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < ROW_COUNT; i++) frame_r[i] <= '0;
    end else begin
      if (cfg_we) period_r <= cfg_wdata;
      if (cmd.update) begin
        frame_r <= frame_nxt;
        if (mode_r == MODE_UP && advance) begin
          up_last_r  <= now_r;
          up_phase_r <= up_phase_r + ROW_W'(1);
        end
        if (mode_r == MODE_DOWN && advance) begin
          down_last_r  <= now_r;
          down_phase_r <= down_phase_r + ROW_W'(1);
        end
      end
      if (cmd.emit) begin
        row_r       <= row_r + ROW_W'(1);
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.row_last = (row_r == LAST_ROW_IDX);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_row_select  = row_sel_r;
  assign out_column_bits = col_r;
  assign out_last_row    = last_r;

`ifndef SYNTH
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("row loaded but output not valid");

  a_one_cold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot(~row_sel_r))
    else $error("row select is not one-cold");

  a_last_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (last_r == !row_sel_r[ROW_COUNT-1]))
    else $error("last row flag does not match row select");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.emit)
    else $error("output register overwritten while held");

  a_row_zero_on_update: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> (row_r == '0))
    else $error("scan counter not at row zero at frame update");
`endif

endmodule

`default_nettype wire

// File: rtl/led_matrix_glyph_scroller_unit.sv
// Top level of the 8x8 LED glyph scroller: sequencer plus datapath.
// Depends on lmgs_pkg, lmgs_ifs, lmgs_ctrl and lmgs_datapath.
//
//  channel  | direction | handshake      | payload
//  in_ch    | in        | valid/ready    | mode[1:0], floor[7:0], now_ms[31:0]
//  out_ch   | out       | valid/ready    | row_select[7:0], column_bits[7:0], last_row
//  cfg_*    | in        | cfg_we strobe  | cfg_wdata[15:0] = scroll period in ms
//
// A request is accepted, its frame is updated, then its eight rows are scanned, one
// per cycle with no back-pressure, through the single frame read port.
// After S_UPDATE, S_SCAN loads the first row into the output register; out_ch stalls hold the scan.
// The next request is accepted while the last row still waits in the output register.
// Reset (rst_n low, synchronous) clears the frame, timers, phases and sets period 100.
`default_nettype none

module led_matrix_glyph_scroller_unit
  import lmgs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  lmgs_in_if.sink          in_ch,
  lmgs_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  lmgs_cmd_t cmd;
  lmgs_sts_t sts;
  logic      in_ready;

  assign in_ch.ready = in_ready;

  lmgs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lmgs_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_mode         (in_ch.mode),
    .in_floor        (in_ch.floor),
    .in_now_ms       (in_ch.now_ms),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_row_select  (out_ch.row_select),
    .out_column_bits (out_ch.column_bits),
    .out_last_row    (out_ch.last_row)
  );

endmodule

`default_nettype wire
